>>> hdl/lzw_decode_dictionary_macros.svh
// Assertion macros used by the LZW dictionary back end.
`ifndef LZW_DECODE_DICTIONARY_MACROS_SVH
`define LZW_DECODE_DICTIONARY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lzd_pkg.sv
// Package: constants, types and state codes of the LZW decode dictionary.
`timescale 1ns / 1ps
package lzd_pkg;
    localparam int CodeBits   = 16;
    localparam int TableDepth = (1 << CodeBits) - 256;
    localparam int BufDepth   = TableDepth + 1;
    localparam int WalkLimit  = BufDepth - 1;
    localparam int TblAw      = $clog2(TableDepth);
    localparam int BufAw      = $clog2(BufDepth);
    localparam int CntW       = $clog2(BufDepth + 1);
    localparam int FfcW       = 9;
    localparam logic [FfcW-1:0] FfcReset = 9'd257;

    localparam logic [1:0] FuncExpand = 2'd0;
    localparam logic [1:0] FuncAdd    = 2'd1;
    localparam logic [1:0] FuncPop    = 2'd2;
    localparam logic [1:0] FuncNone   = 2'd3;

    typedef enum logic [1:0] {OP_EXPAND, OP_ADD, OP_POP, OP_NOP} t_op;

    typedef struct packed {
        t_op                 op;
        logic [CodeBits-1:0] start;
        logic                repeat_first;
        logic                add_en;
        logic [TblAw-1:0]    add_idx;
        logic [CodeBits-1:0] prefix;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_STEP, ST_FIX, ST_ADD, ST_POP, ST_OUT
    } t_state;
endpackage

>>> hdl/lzd_front.sv
// Front end: accepts words, classifies them and queues the commands.
`timescale 1ns / 1ps
module lzd_front import lzd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [FfcW-1:0]     i_ffc,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_func,
    input  logic [CodeBits-1:0] i_code,
    input  logic [CodeBits-1:0] i_prev_code,
    input  logic [CodeBits-1:0] i_new_code,
    output logic                o_q_valid,
    output t_cmd                o_q_cmd,
    input  logic                i_q_pop
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_kwk;

    always_comb begin
        w_kwk = (i_code == i_new_code);
        w_cmd = '0;
        unique case (i_func)
            FuncExpand: w_cmd.op = OP_EXPAND;
            FuncAdd:    w_cmd.op = OP_ADD;
            FuncPop:    w_cmd.op = OP_POP;
            FuncNone:   w_cmd.op = OP_NOP;
            default:    w_cmd.op = OP_NOP;
        endcase
        w_cmd.repeat_first = (i_func == FuncAdd) && w_kwk;
        w_cmd.start        = w_cmd.repeat_first ? i_prev_code : i_code;
        w_cmd.add_en       = (i_func == FuncAdd) &&
                             (i_new_code >= CodeBits'(i_ffc));
        w_cmd.add_idx      = TblAw'(i_new_code - CodeBits'(i_ffc));
        w_cmd.prefix       = i_prev_code;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_cmd;
    end
endmodule

>>> hdl/lzd_back.sv
// Back end: dictionary walk, string buffer, table update and output register.
`timescale 1ns / 1ps
module lzd_back import lzd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [FfcW-1:0]     i_ffc,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_symbol,
    output logic [15:0]         o_string_length,
    output logic                o_has_more
);
    logic [CodeBits-1:0] prefix_table [TableDepth];
    logic [7:0]          suffix_table [TableDepth];
    logic [7:0]          string_buffer [BufDepth];

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [CodeBits-1:0] r_code, n_code;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic [7:0]          r_sym, n_sym;
    logic                r_o_valid;
    logic [7:0]          r_o_sym;
    logic [15:0]         r_o_len;
    logic                r_o_more;

    logic                w_walk, w_out_free;
    logic                w_tbl_re, w_tbl_we, w_buf_re, w_buf_we;
    logic [TblAw-1:0]    w_tbl_addr;
    logic [BufAw-1:0]    w_buf_waddr, w_buf_raddr;
    logic [7:0]          w_buf_wdata;
    logic [CodeBits-1:0] r_pre_rd;
    logic [7:0]          r_suf_rd, r_buf_rd;

    assign w_walk     = (r_code >= CodeBits'(i_ffc)) && (r_cnt < CntW'(WalkLimit));
    assign w_out_free = !r_o_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_EXPAND, OP_ADD: n_state = ST_LOOK;
                        OP_POP:  n_state = (r_cnt != '0) ? ST_POP : ST_OUT;
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_LOOK: begin
                if (w_walk) n_state = ST_STEP;
                else if (r_cmd.repeat_first) n_state = ST_FIX;
                else if (r_cmd.add_en) n_state = ST_ADD;
                else n_state = ST_OUT;
            end
            ST_STEP: n_state = ST_LOOK;
            ST_FIX:  n_state = r_cmd.add_en ? ST_ADD : ST_OUT;
            ST_ADD:  n_state = ST_OUT;
            ST_POP:  n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd       = r_cmd;
        n_code      = r_code;
        n_cnt       = r_cnt;
        n_sym       = r_sym;
        o_q_pop     = 1'b0;
        w_tbl_re    = 1'b0;
        w_tbl_we    = 1'b0;
        w_tbl_addr  = r_cmd.add_idx;
        w_buf_re    = 1'b0;
        w_buf_we    = 1'b0;
        w_buf_waddr = r_cnt[BufAw-1:0];
        w_buf_raddr = BufAw'(r_cnt - CntW'(1));
        w_buf_wdata = r_code[7:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_sym   = 8'd0;
                    case (i_q_cmd.op)
                        OP_EXPAND, OP_ADD: begin
                            n_code = i_q_cmd.start;
                            n_cnt  = CntW'(i_q_cmd.repeat_first);
                        end
                        OP_POP: begin
                            if (r_cnt != '0) begin
                                w_buf_re = 1'b1;
                                n_cnt    = r_cnt - CntW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOK: begin
                if (w_walk) begin
                    w_tbl_re   = 1'b1;
                    w_tbl_addr = TblAw'(r_code - CodeBits'(i_ffc));
                end else begin
                    // literal reached or walk limit hit: store it last, it is also the first symbol
                    w_buf_we = 1'b1;
                    n_cnt    = r_cnt + CntW'(1);
                    n_sym    = r_code[7:0];
                end
            end
            ST_STEP: begin
                w_buf_we    = 1'b1;
                w_buf_wdata = r_suf_rd;
                n_cnt       = r_cnt + CntW'(1);
                n_code      = r_pre_rd;
            end
            ST_FIX: begin
                w_buf_we    = 1'b1;
                w_buf_waddr = '0;
                w_buf_wdata = r_sym;
            end
            ST_ADD:  w_tbl_we = 1'b1;
            ST_POP:  n_sym = r_buf_rd;
            ST_OUT:  ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_OUT && w_out_free) r_o_valid <= 1'b1;
            else if (!i_out_stall) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_code <= n_code;
        r_sym  <= n_sym;
        if (r_state == ST_OUT && w_out_free) begin
            r_o_sym  <= r_sym;
            r_o_len  <= r_cnt[15:0];
            r_o_more <= (r_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            prefix_table[w_tbl_addr] <= r_cmd.prefix;
            suffix_table[w_tbl_addr] <= r_sym;
        end
        if (w_tbl_re) begin
            r_pre_rd <= prefix_table[w_tbl_addr];
            r_suf_rd <= suffix_table[w_tbl_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) string_buffer[w_buf_waddr] <= w_buf_wdata;
        if (w_buf_re) r_buf_rd <= string_buffer[w_buf_raddr];
    end

    assign o_out_valid     = r_o_valid;
    assign o_symbol        = r_o_sym;
    assign o_string_length = r_o_len;
    assign o_has_more      = r_o_more;

`include "lzw_decode_dictionary_macros.svh"
    `LZD_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CntW'(BufDepth), "string count overflow")
    `LZD_ASSERT_NOW(a_step_order, r_state == ST_STEP, $past(r_state) == ST_LOOK, "step without lookup")
    `LZD_ASSERT_NEXT(a_pop_dec, r_state == ST_IDLE && i_q_valid && i_q_cmd.op == OP_POP && r_cnt != '0, r_state == ST_POP && r_cnt == $past(r_cnt) - CntW'(1), "pop did not decrement")
endmodule

>>> hdl/lzw_decode_dictionary.sv
// LZW decode dictionary: top level joining front end, command queue and back end.
//
// One word in gives one word out. func 0 expands a code by walking its prefix
// chain, func 1 expands and then adds (previous code, first symbol) at the new
// code, func 2 pops the next byte of the expanded string, func 3 only reports
// the buffer. An expansion takes the command, then for each dictionary entry
// walked does one registered table read and one buffer write, then writes the
// literal, does the optional repeat fix and table write, and loads the output.
// A pop takes the command, does a registered string buffer read and loads the
// output; a pop of an empty buffer or func 3 takes the command and loads the
// output. A stalled output holds the back end at the output load. The walk
// loop over the single-port tables is what bounds throughput. A two-entry
// queue sits behind the input, so the input keeps taking words until the queue
// is full while the back end walks or a result waits behind a stalled output.
// The string buffer and both tables come out of reset undefined; reading a
// table entry that was never written gives an undefined string. The user must
// write the base code register (lowest dictionary code, reset 257) through
// i_cfg_we/i_cfg_data only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module lzw_decode_dictionary import lzd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [FfcW-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_func,
    input  logic [CodeBits-1:0] i_code,
    input  logic [CodeBits-1:0] i_prev_code,
    input  logic [CodeBits-1:0] i_new_code,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_symbol,
    output logic [15:0]         o_string_length,
    output logic                o_has_more
);
    logic [FfcW-1:0] r_ffc;
    logic            w_q_valid, w_q_pop;
    t_cmd            w_q_cmd;

    // hold the base code; update only on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ffc <= FfcReset;
        end else if (i_cfg_we) begin
            r_ffc <= i_cfg_data;
        end
    end

    lzd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ffc         (r_ffc),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_code        (i_code),
        .i_prev_code   (i_prev_code),
        .i_new_code    (i_new_code),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    lzd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ffc           (r_ffc),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_cmd),
        .o_q_pop         (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_symbol        (o_symbol),
        .o_string_length (o_string_length),
        .o_has_more      (o_has_more)
    );
endmodule

>>> verif/lzw_decode_dictionary_check.sv
// Checker for the LZW decode dictionary: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module lzw_decode_dictionary_check import lzd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [FfcW-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [1:0]          i_func,
    input  logic [CodeBits-1:0] i_code,
    input  logic [CodeBits-1:0] i_prev_code,
    input  logic [CodeBits-1:0] i_new_code,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [7:0]          i_symbol,
    input  logic [15:0]         i_string_length,
    input  logic                i_has_more,
    output int                  o_fail_count,
    output int                  o_pending
);
    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] length;
        logic        more;
    } t_word;

    logic [CodeBits-1:0] dict_prefix [0:TableDepth-1];
    logic [7:0]          dict_suffix [0:TableDepth-1];
    logic [7:0]          str_bytes   [0:BufDepth-1];
    int                  str_count;
    logic [FfcW-1:0]     first_free;
    t_word               expected_words [$];

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Walk the prefix chain, fill the string in reverse, return the first symbol.
    function automatic logic [7:0] expand_string(logic [CodeBits-1:0] start, bit repeat_first);
        int                  n;
        int                  idx;
        logic [CodeBits-1:0] c;
        logic [7:0]          first;
        n = repeat_first ? 1 : 0;
        c = start;
        while (c >= first_free && n < BufDepth - 1) begin
            idx = c - first_free;
            str_bytes[n] = dict_suffix[idx];
            n++;
            c = dict_prefix[idx];
        end
        first = c[7:0];
        str_bytes[n] = first;
        n++;
        if (repeat_first) begin
            str_bytes[0] = first;
        end
        str_count = n;
        return first;
    endfunction

    function automatic t_word predict_word(logic [1:0] op, logic [CodeBits-1:0] code,
                                           logic [CodeBits-1:0] prefix,
                                           logic [CodeBits-1:0] next);
        t_word w;
        bit    kwk;
        int    idx;
        w.symbol = 8'd0;
        if (op == FuncExpand) begin
            w.symbol = expand_string(code, 1'b0);
        end else if (op == FuncAdd) begin
            kwk = (code == next);
            w.symbol = expand_string(kwk ? prefix : code, kwk);
            if (next >= first_free) begin
                idx = next - first_free;
                if (idx < TableDepth) begin
                    dict_prefix[idx] = prefix;
                    dict_suffix[idx] = w.symbol;
                end
            end
        end else if (op == FuncPop) begin
            if (str_count > 0 && str_count <= BufDepth) begin
                str_count--;
                w.symbol = str_bytes[str_count];
            end
        end
        w.length = str_count[15:0];
        w.more   = (str_count != 0);
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            first_free   = FfcReset;
            str_count    = 0;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                first_free = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(predict_word(i_func, i_code, i_prev_code,
                                                      i_new_code));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_symbol, i_string_length, i_has_more};
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, symbol", int'(got.symbol), 0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.symbol !== want.symbol)
                        report_mismatch("symbol", int'(got.symbol), int'(want.symbol));
                    if (got.length !== want.length)
                        report_mismatch("string_length", int'(got.length),
                                        int'(want.length));
                    if (got.more !== want.more)
                        report_mismatch("has_more", int'(got.more), int'(want.more));
                end
            end
        end
        o_pending = expected_words.size();
    end
endmodule

>>> verif/lzw_decode_dictionary_test.sv
// Testbench top for the LZW decode dictionary: stimulus, idling and verdict.
`timescale 1ns / 1ps
module lzw_decode_dictionary_test;
    import lzd_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam int ChainLimit = 64;   // deepest chain the random part may expand

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [FfcW-1:0]     i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_func;
    logic [CodeBits-1:0] i_code;
    logic [CodeBits-1:0] i_prev_code;
    logic [CodeBits-1:0] i_new_code;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [7:0]          o_symbol;
    logic [15:0]         o_string_length;
    logic                o_has_more;
    int                  fail_count;
    int                  pending;
    int                  cycles;
    int                  send_idle;
    int                  recv_idle;

    // Shadow of which dictionary slots hold an entry, and their prefixes:
    // used only to keep the stimulus away from never-written entries.
    bit                  slot_used   [0:TableDepth-1];
    logic [CodeBits-1:0] slot_prefix [0:TableDepth-1];
    logic [CodeBits-1:0] added_codes [$];
    logic [FfcW-1:0]     first_free;

    lzw_decode_dictionary u_top (.*);

    lzw_decode_dictionary_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_code          (i_code),
        .i_prev_code     (i_prev_code),
        .i_new_code      (i_new_code),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_symbol        (o_symbol),
        .i_string_length (o_string_length),
        .i_has_more      (o_has_more),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: the one long chain walk plus all idling fits well inside.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver stalls at the configured rate.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    // True if expanding this code only touches written entries and the chain
    // stays short (this also rejects loops).
    function automatic bit chain_ok(logic [CodeBits-1:0] start);
        logic [CodeBits-1:0] c;
        int                  steps;
        int                  idx;
        c = start;
        steps = 0;
        while (c >= first_free) begin
            idx = c - first_free;
            if (!slot_used[idx] || steps >= ChainLimit) return 1'b0;
            c = slot_prefix[idx];
            steps++;
        end
        return 1'b1;
    endfunction

    // Literal or a safe dictionary code.
    function automatic logic [CodeBits-1:0] pick_code();
        logic [CodeBits-1:0] c;
        if (added_codes.size() != 0 && $urandom_range(99) < 65) begin
            c = added_codes[$urandom_range(added_codes.size() - 1)];
            if (chain_ok(c)) return c;
        end
        return CodeBits'($urandom_range(first_free - 1));
    endfunction

    // Random code at or above first_free whose slot is still empty.
    function automatic logic [CodeBits-1:0] fresh_code();
        logic [CodeBits-1:0] c;
        do begin
            c = CodeBits'($urandom_range(16'hFFFF, first_free));
        end while (slot_used[c - first_free]);
        return c;
    endfunction

    // Present one word and hold it until it is taken.
    task automatic send_word(logic [1:0] op, logic [CodeBits-1:0] code,
                             logic [CodeBits-1:0] prefix, logic [CodeBits-1:0] next);
        int idx;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_func      = op;
        i_code      = code;
        i_prev_code = prefix;
        i_new_code  = next;
        if (op == FuncAdd && next >= first_free) begin
            idx = next - first_free;
            slot_used[idx]   = 1'b1;
            slot_prefix[idx] = prefix;
            added_codes.push_back(next);
        end
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Hold off until the block has drained, then set the register.
    task automatic write_first_free(logic [FfcW-1:0] value);
        wait (pending == 0);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        first_free = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic random_words(int count);
        logic [1:0]          op;
        logic [CodeBits-1:0] code;
        logic [CodeBits-1:0] prefix;
        logic [CodeBits-1:0] next;
        int                  roll;
        repeat (count) begin
            roll   = $urandom_range(99);
            code   = CodeBits'($urandom);
            prefix = CodeBits'($urandom);
            next   = CodeBits'($urandom);
            if (roll < 35) begin
                op     = FuncAdd;
                prefix = pick_code();
                roll   = $urandom_range(99);
                if (roll < 15) begin
                    next = fresh_code();
                    code = next;               // KwKwK
                end else begin
                    code = pick_code();
                    if (roll < 25)
                        next = CodeBits'($urandom_range(first_free - 1));   // write dropped
                    else if (roll < 30 && added_codes.size() != 0)
                        next = added_codes[$urandom_range(added_codes.size() - 1)];
                    else
                        next = fresh_code();
                    if (code == next) code = CodeBits'($urandom_range(255));
                end
            end else if (roll < 65) begin
                op   = FuncExpand;
                code = pick_code();
            end else if (roll < 95) begin
                op = FuncPop;
            end else begin
                op = FuncNone;
            end
            send_word(op, code, prefix, next);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_func      = FuncExpand;
        i_code      = '0;
        i_prev_code = '0;
        i_new_code  = '0;
        send_idle   = 0;
        recv_idle   = 0;
        first_free  = FfcReset;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty pop, literals, clear code, chains, KwKwK, dropped
        // writes, extreme codes and one endless chain.
        send_word(FuncPop,    16'd0,     16'hFFFF,  16'hFFFF);
        send_word(FuncNone,   16'hFFFF,  16'hFFFF,  16'hFFFF);
        send_word(FuncExpand, 16'd0,     16'd0,     16'd0);
        send_word(FuncExpand, 16'd255,   16'd0,     16'd0);
        send_word(FuncExpand, 16'd256,   16'd0,     16'd0);
        send_word(FuncAdd,    16'd65,    16'd66,    16'd257);
        send_word(FuncAdd,    16'd257,   16'd257,   16'd258);
        send_word(FuncExpand, 16'd258,   16'd0,     16'd0);
        send_word(FuncPop,    16'd0,     16'd0,     16'd0);
        send_word(FuncNone,   16'd0,     16'd0,     16'd0);
        send_word(FuncAdd,    16'd259,   16'd258,   16'd259);
        send_word(FuncPop,    16'd0,     16'd0,     16'd0);
        send_word(FuncPop,    16'd0,     16'd0,     16'd0);
        send_word(FuncAdd,    16'd7,     16'd8,     16'd100);
        send_word(FuncAdd,    16'hFFFF,  16'd255,   16'hFFFF);
        send_word(FuncExpand, 16'hFFFF,  16'd0,     16'd0);
        send_word(FuncPop,    16'd0,     16'd0,     16'd0);
        send_word(FuncAdd,    16'd1,     16'd60000, 16'd60000);
        send_word(FuncExpand, 16'd60000, 16'd0,     16'd0);
        send_word(FuncPop,    16'd0,     16'd0,     16'd0);
        send_word(FuncAdd,    16'd258,   16'd259,   16'd260);
        send_word(FuncPop,    16'd0,     16'd0,     16'd0);

        // Random phases: receiver-heavy stalls, then sender-heavy, then none.
        write_first_free(9'd256);
        send_idle = 20;
        recv_idle = 54;
        random_words(500);
        write_first_free(9'd257);
        send_idle = 54;
        recv_idle = 20;
        random_words(500);
        write_first_free(9'd256);
        send_idle = 0;
        recv_idle = 0;
        random_words(500);

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
